// ----- src/bwm_pkg.sv -----
// Shared types, codes and constants for the barcode whitelist matcher.
// Used by bwm_cell and barcode_whitelist_mismatch_match_top; no dependencies.
package bwm_pkg;

   localparam int ENTRIES_DEF    = 4096;
   localparam int MAX_BASES_DEF  = 32;
   localparam int BASES_PER_CELL = 8;
   localparam int CELL_BITS      = 2 * BASES_PER_CELL;

   localparam logic [63:0] LOW_BITS = 64'h5555555555555555;

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   localparam logic [1:0] ST_MATCHED   = 2'd0;
   localparam logic [1:0] ST_TOO_MANY_N = 2'd1;
   localparam logic [1:0] ST_NO_MATCH  = 2'd2;
   localparam logic [1:0] ST_LOADED    = 2'd3;

   localparam logic [1:0] REG_MISMATCH_LIMIT = 2'd0;
   localparam logic [1:0] REG_BARCODE_LENGTH = 2'd1;
   localparam logic [1:0] REG_ENTRY_COUNT    = 2'd2;

   typedef struct packed {
      logic        valid;
      logic        last;
      logic [11:0] idx;
      logic [63:0] word;
      logic [63:0] diff;
      logic [5:0]  cnt;
   } cell_data_type;

   function automatic logic [3:0] count8(input logic [7:0] v);
      logic [3:0] n;
      n = 4'd0;
      for (int i = 0; i < 8; i++) begin
         n = n + {3'd0, v[i]};
      end
      return n;
   endfunction

endpackage

// ----- src/bwm_store.sv -----
// Whitelist memory: one write port and one read port with registered read data.
// No package dependencies.
module bwm_store #(
   parameter int ENTRIES = 4096,
   parameter int ADDR_W  = 12
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [63:0]       wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [63:0]       rd_data
);

   logic [63:0] mem [ENTRIES];
   logic [63:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/bwm_cell.sv -----
// One cell of the compare chain: counts mismatching bases in its slice of the
// difference vector and hands the item to the next cell. Depends on bwm_pkg.
module bwm_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   flush,
   input  bwm_pkg::cell_data_type cell_in,
   output bwm_pkg::cell_data_type cell_out
);

   bwm_pkg::cell_data_type out_ff;
   bwm_pkg::cell_data_type out_in;
   logic [7:0]             base_diff;

   always_comb begin
      for (int b = 0; b < bwm_pkg::BASES_PER_CELL; b++) begin
         base_diff[b] = cell_in.diff[2*b] | cell_in.diff[2*b+1];
      end
      out_in       = cell_in;
      out_in.valid = cell_in.valid & ~flush;
      out_in.diff  = cell_in.diff >> bwm_pkg::CELL_BITS;
      out_in.cnt   = cell_in.cnt + {2'd0, bwm_pkg::count8(base_diff)};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else begin
         out_ff.valid <= out_in.valid;
      end
      out_ff.last <= out_in.last;
      out_ff.idx  <= out_in.idx;
      out_ff.word <= out_in.word;
      out_ff.diff <= out_in.diff;
      out_ff.cnt  <= out_in.cnt;
   end

   assign cell_out = out_ff;

endmodule

// ----- src/barcode_whitelist_mismatch_match_top.sv -----
// Top level of the barcode whitelist matcher with a mismatch budget.
// Depends on bwm_pkg, bwm_store and bwm_cell.
//
// An item is accepted when start is high and busy is low. A load item
// (req_type 0) writes req_barcode into slot req_entry_index and answers in
// the next cycle with status 3. A query item first counts its N bases; if
// that count exceeds mismatch_limit it answers with status 1.
// Otherwise slots are read from the whitelist memory one per cycle and pass
// down a chain of compare cells, each covering eight bases, so that a new
// slot enters the chain every cycle. The first slot within the limit ends the
// scan with status 0; if none is found the answer is status 2.
// The item rate is one query at a time; busy stays high until its result
// is shown. Each result is shown for exactly one cycle with rsp_valid high;
// the receiver cannot stall it. Registers are written through the csr_
// channel, always ready; the user must write them only while the block is
// idle, and the block itself does not enforce this. Reset restores the
// register reset values and idles the block; the whitelist is undefined
// until written.
module barcode_whitelist_mismatch_match_top #(
   parameter int ENTRIES   = bwm_pkg::ENTRIES_DEF,
   parameter int MAX_BASES = bwm_pkg::MAX_BASES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_type,
   input  logic [11:0] req_entry_index,
   input  logic [63:0] req_barcode,
   input  logic [31:0] req_n_mask,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [11:0] rsp_match_index,
   output logic [63:0] rsp_match_code,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_data
);

   localparam int ADDR_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W     = $clog2(ENTRIES + 1);
   localparam int NUM_CELLS = (MAX_BASES + bwm_pkg::BASES_PER_CELL - 1)
                              / bwm_pkg::BASES_PER_CELL;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_NCNT = 2'd1;
   localparam logic [1:0] S_SCAN = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [5:0]        limit_ff, limit_in;
   logic [5:0]        length_ff, length_in;
   logic [12:0]       count_ff, count_in;
   logic [63:0]       q_code_ff, q_code_in;
   logic [63:0]       q_mask_ff, q_mask_in;
   logic [31:0]       q_nlo_ff, q_nlo_in;
   logic [5:0]        num_n_ff, num_n_in;
   logic [CNT_W-1:0]  scan_ff, scan_in;
   logic [CNT_W-1:0]  rd_cnt_ff, rd_cnt_in;
   logic              issue_ff, issue_in;
   logic              rd_valid_ff, rd_valid_in;
   logic              rd_last_ff, rd_last_in;
   logic [11:0]       rd_idx_ff, rd_idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [11:0]       rsp_index_ff, rsp_index_in;
   logic [63:0]       rsp_code_ff, rsp_code_in;

   logic [5:0]        len_sat;
   logic [63:0]       base_mask;
   logic [31:0]       nlen_mask;
   logic [31:0]       n_lo;
   logic [63:0]       n_pairs;
   logic [5:0]        num_n;
   logic [31:0]       slot_ext;
   logic [31:0]       count_ext;
   logic [31:0]       scan_full;
   logic [31:0]       rd_cnt_ext;
   logic              wr_en;
   logic              flush;
   logic              hit;
   logic [6:0]        total;
   logic [63:0]       rd_data;

   bwm_pkg::cell_data_type head;
   bwm_pkg::cell_data_type chain [NUM_CELLS+1];
   bwm_pkg::cell_data_type tail;

   bwm_store #(
      .ENTRIES (ENTRIES),
      .ADDR_W  (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (slot_ext[ADDR_W-1:0]),
      .wr_data (req_barcode),
      .rd_addr (rd_cnt_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      head.valid = rd_valid_ff;
      head.last  = rd_last_ff;
      head.idx   = rd_idx_ff;
      head.word  = rd_data;
      head.diff  = (rd_data ^ q_code_ff) & q_mask_ff;
      head.cnt   = 6'd0;
   end

   assign chain[0] = head;

   for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
      bwm_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .flush    (flush),
         .cell_in  (chain[c]),
         .cell_out (chain[c+1])
      );
   end

   assign tail  = chain[NUM_CELLS];
   assign total = {1'b0, tail.cnt} + {1'b0, num_n_ff};
   assign hit   = total <= {1'b0, limit_ff};

   assign slot_ext   = {20'd0, req_entry_index};
   assign count_ext  = {19'd0, count_ff};
   assign scan_full  = (count_ext > 32'(ENTRIES)) ? 32'(ENTRIES) : count_ext;
   assign rd_cnt_ext = 32'(rd_cnt_ff);

   always_comb begin
      len_sat = (length_ff > 6'(MAX_BASES)) ? 6'(MAX_BASES) : length_ff;
      if (len_sat >= 6'd32) begin
         base_mask = '1;
         nlen_mask = '1;
      end else begin
         base_mask = (64'd1 << {len_sat, 1'b0}) - 64'd1;
         nlen_mask = (32'd1 << len_sat[4:0]) - 32'd1;
      end
      n_lo = req_n_mask & nlen_mask;
      for (int k = 0; k < 32; k++) begin
         n_pairs[2*k +: 2] = {2{n_lo[k]}};
      end
   end

   always_comb begin
      num_n = 6'd0;
      for (int g = 0; g < 4; g++) begin
         num_n = num_n + {2'd0, bwm_pkg::count8(q_nlo_ff[8*g +: 8])};
      end
   end

   always_comb begin
      state_in      = state_ff;
      q_code_in     = q_code_ff;
      q_mask_in     = q_mask_ff;
      q_nlo_in      = q_nlo_ff;
      num_n_in      = num_n_ff;
      scan_in       = scan_ff;
      rd_cnt_in     = rd_cnt_ff;
      issue_in      = issue_ff;
      rd_valid_in   = 1'b0;
      rd_last_in    = rd_last_ff;
      rd_idx_in     = rd_idx_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_code_in   = rsp_code_ff;
      wr_en         = 1'b0;
      flush         = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_type == bwm_pkg::REQ_LOAD) begin
                  wr_en         = slot_ext < 32'(ENTRIES);
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = bwm_pkg::ST_LOADED;
                  rsp_index_in  = 12'd0;
                  rsp_code_in   = 64'd0;
               end else begin
                  q_code_in = req_barcode;
                  q_mask_in = base_mask & ~n_pairs;
                  q_nlo_in  = n_lo;
                  state_in  = S_NCNT;
               end
            end
         end
         S_NCNT: begin
            rsp_index_in = 12'd0;
            rsp_code_in  = 64'd0;
            if (num_n > limit_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = bwm_pkg::ST_TOO_MANY_N;
               state_in      = S_IDLE;
            end else if (scan_full == 32'd0) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = bwm_pkg::ST_NO_MATCH;
               state_in      = S_IDLE;
            end else begin
               num_n_in  = num_n;
               scan_in   = scan_full[CNT_W-1:0];
               rd_cnt_in = '0;
               issue_in  = 1'b1;
               state_in  = S_SCAN;
            end
         end
         S_SCAN: begin
            if (issue_ff) begin
               rd_valid_in = 1'b1;
               rd_idx_in   = rd_cnt_ext[11:0];
               rd_last_in  = rd_cnt_ff == (scan_ff - CNT_W'(1));
               rd_cnt_in   = rd_cnt_ff + CNT_W'(1);
               if (rd_last_in) begin
                  issue_in = 1'b0;
               end
            end
            if (tail.valid && (hit || tail.last)) begin
               flush        = 1'b1;
               rd_valid_in  = 1'b0;
               issue_in     = 1'b0;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (hit) begin
                  rsp_status_in = bwm_pkg::ST_MATCHED;
                  rsp_index_in  = tail.idx;
                  rsp_code_in   = tail.word;
               end else begin
                  rsp_status_in = bwm_pkg::ST_NO_MATCH;
                  rsp_index_in  = 12'd0;
                  rsp_code_in   = 64'd0;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
            issue_in = 1'b0;
         end
      endcase
   end

   always_comb begin
      limit_in  = limit_ff;
      length_in = length_ff;
      count_in  = count_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            bwm_pkg::REG_MISMATCH_LIMIT: limit_in  = csr_data[5:0];
            bwm_pkg::REG_BARCODE_LENGTH: length_in = csr_data[5:0];
            bwm_pkg::REG_ENTRY_COUNT:    count_in  = csr_data;
            default: begin
               limit_in = limit_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         issue_ff     <= 1'b0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         limit_ff     <= 6'd1;
         length_ff    <= 6'd16;
         count_ff     <= 13'd0;
      end else begin
         state_ff     <= state_in;
         issue_ff     <= issue_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         limit_ff     <= limit_in;
         length_ff    <= length_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      q_code_ff     <= q_code_in;
      q_mask_ff     <= q_mask_in;
      q_nlo_ff      <= q_nlo_in;
      num_n_ff      <= num_n_in;
      scan_ff       <= scan_in;
      rd_cnt_ff     <= rd_cnt_in;
      rd_last_ff    <= rd_last_in;
      rd_idx_ff     <= rd_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_code_ff   <= rsp_code_in;
   end

   assign busy            = state_ff != S_IDLE;
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_match_index = rsp_index_ff;
   assign rsp_match_code  = rsp_code_ff;

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for barcode_whitelist_mismatch_match_top. Depends on
// bwm_pkg and the RTL; loads the whitelist and predicts every answer locally.
module tb_top;

   localparam int ENTRIES      = bwm_pkg::ENTRIES_DEF;
   localparam int MAX_BASES    = bwm_pkg::MAX_BASES_DEF;
   localparam int FILLED       = 32;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 64;

   typedef struct packed {
      logic [1:0]  status;
      logic [11:0] index;
      logic [63:0] code;
   } answer_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_type;
   logic [11:0] req_entry_index;
   logic [63:0] req_barcode;
   logic [31:0] req_n_mask;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [11:0] rsp_match_index;
   logic [63:0] rsp_match_code;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [12:0] csr_data;

   answer_type  expected_answers[$];
   answer_type  want;
   logic [63:0] whitelist_copy [ENTRIES];
   logic [5:0]  limit_reg;
   logic [5:0]  length_reg;
   logic [12:0] count_reg;
   int          errors = 0;
   int          cycles = 0;
   bit          no_gaps = 1'b0;

   barcode_whitelist_mismatch_match_top uut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_entry_index (req_entry_index),
      .req_barcode     (req_barcode),
      .req_n_mask      (req_n_mask),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_match_index (rsp_match_index),
      .rsp_match_code  (rsp_match_code),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles = cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic int compared_bases();
      return (length_reg > MAX_BASES) ? MAX_BASES : int'(length_reg);
   endfunction

   function automatic answer_type match_barcode(input logic [63:0] code,
                                                input logic [31:0] nmask);
      answer_type  ans;
      int          bases;
      int          scan;
      int          num_n;
      logic [63:0] base_mask;
      logic [63:0] n_pairs;
      logic [63:0] diff;
      logic [63:0] per_base;
      ans = '0;
      bases = compared_bases();
      base_mask = (bases >= 32) ? '1 : (64'd1 << (2 * bases)) - 64'd1;
      n_pairs = '0;
      for (int k = 0; k < bases; k++) begin
         if (nmask[k]) n_pairs = n_pairs | (64'd3 << (2 * k));
      end
      num_n = $countones(n_pairs & bwm_pkg::LOW_BITS);
      if (num_n > int'(limit_reg)) begin
         ans.status = bwm_pkg::ST_TOO_MANY_N;
         return ans;
      end
      scan = (count_reg > ENTRIES) ? ENTRIES : int'(count_reg);
      for (int k = 0; k < scan; k++) begin
         diff = (whitelist_copy[k] ^ code) & base_mask & ~n_pairs;
         per_base = (diff | (diff >> 1)) & bwm_pkg::LOW_BITS;
         if ($countones(per_base) + num_n <= int'(limit_reg)) begin
            ans.status = bwm_pkg::ST_MATCHED;
            ans.index = 12'(k);
            ans.code = whitelist_copy[k];
            return ans;
         end
      end
      ans.status = bwm_pkg::ST_NO_MATCH;
      return ans;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_answers.size() == 0) begin
            $error("unexpected answer: status %0d index %0d code %h",
                   rsp_status, rsp_match_index, rsp_match_code);
            errors++;
         end else begin
            want = expected_answers.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               errors++;
            end
            if (rsp_match_index !== want.index) begin
               $error("match_index: expected %0d, got %0d", want.index, rsp_match_index);
               errors++;
            end
            if (rsp_match_code !== want.code) begin
               $error("match_code: expected %h, got %h", want.code, rsp_match_code);
               errors++;
            end
         end
      end
   end

   // Returns at the rising edge where the item is taken.
   task automatic send_item(input logic kind, input logic [11:0] slot,
                            input logic [63:0] code, input logic [31:0] nmask);
      answer_type ans;
      @(negedge clock);
      while (!no_gaps && $urandom_range(99) < 13) begin
         start = 1'b0;
         @(negedge clock);
      end
      start = 1'b1;
      req_type = kind;
      req_entry_index = slot;
      req_barcode = code;
      req_n_mask = nmask;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (kind == bwm_pkg::REQ_LOAD) begin
         whitelist_copy[slot] = code;
         ans = '0;
         ans.status = bwm_pkg::ST_LOADED;
      end else begin
         ans = match_barcode(code, nmask);
      end
      expected_answers = {expected_answers, ans};
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [12:0] value);
      @(negedge clock);
      start = 1'b0;
      while (expected_answers.size() != 0 || busy) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         bwm_pkg::REG_MISMATCH_LIMIT: limit_reg = value[5:0];
         bwm_pkg::REG_BARCODE_LENGTH: length_reg = value[5:0];
         bwm_pkg::REG_ENTRY_COUNT:    count_reg = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_regs(input int limit, input int bases, input int count);
      write_reg(bwm_pkg::REG_MISMATCH_LIMIT, 13'(limit));
      write_reg(bwm_pkg::REG_BARCODE_LENGTH, 13'(bases));
      write_reg(bwm_pkg::REG_ENTRY_COUNT, 13'(count));
   endtask

   function automatic logic [63:0] random_word();
      return {$urandom, $urandom};
   endfunction

   // A query built from a stored entry with some bases changed and some marked N.
   task automatic send_near_query(input int slot, input int flips, input int n_count);
      logic [63:0] code;
      logic [31:0] nmask;
      int          bases;
      int          pos;
      bases = compared_bases();
      code = whitelist_copy[slot];
      nmask = '0;
      if (bases > 0) begin
         for (int i = 0; i < flips; i++) begin
            pos = $urandom_range(bases - 1);
            code[2 * pos +: 2] = code[2 * pos +: 2] ^ 2'($urandom_range(3, 1));
         end
         for (int i = 0; i < n_count; i++) nmask[$urandom_range(bases - 1)] = 1'b1;
      end
      if ($urandom_range(1) == 1) begin
         for (int b = 2 * bases; b < 64; b++) code[b] = 1'($urandom_range(1));
         for (int b = bases; b < 32; b++) nmask[b] = 1'($urandom_range(1));
      end
      send_item(bwm_pkg::REQ_QUERY, 12'($urandom), code, nmask);
   endtask

   task automatic test_reset_defaults();
      send_item(bwm_pkg::REQ_QUERY, 12'd0, random_word(), 32'd0);
      send_item(bwm_pkg::REQ_QUERY, 12'd0, random_word(), 32'h0000_0003);
   endtask

   task automatic test_fill_whitelist();
      send_item(bwm_pkg::REQ_LOAD, 12'd0, 64'd0, 32'd0);
      send_item(bwm_pkg::REQ_LOAD, 12'd1, 64'hffff_ffff_ffff_ffff, '1);
      send_item(bwm_pkg::REQ_LOAD, 12'd2, 64'h5555_5555_5555_5555, 32'd0);
      send_item(bwm_pkg::REQ_LOAD, 12'd3, 64'haaaa_aaaa_aaaa_aaaa, 32'd0);
      for (int k = 4; k < FILLED; k++) begin
         send_item(bwm_pkg::REQ_LOAD, 12'(k), random_word(), $urandom);
      end
   endtask

   task automatic test_special_cases();
      set_regs(0, 32, 8);
      send_item(bwm_pkg::REQ_QUERY, 12'd0, 64'h5555_5555_5555_5555, 32'd0);
      send_item(bwm_pkg::REQ_QUERY, 12'd0, 64'hffff_ffff_ffff_ffff, 32'd0);
      send_item(bwm_pkg::REQ_QUERY, 12'd0, 64'd0, 32'h0000_0001);
      // With no bases compared, every scanned entry matches.
      write_reg(bwm_pkg::REG_BARCODE_LENGTH, 13'd0);
      send_item(bwm_pkg::REQ_QUERY, 12'd0, random_word(), '1);
      // An over-long length is taken as the full barcode.
      set_regs(32, 63, 8);
      send_item(bwm_pkg::REQ_QUERY, 12'd0, random_word(), '1);
      write_reg(bwm_pkg::REG_MISMATCH_LIMIT, 13'd31);
      send_item(bwm_pkg::REQ_QUERY, 12'd0, random_word(), '1);
      write_reg(bwm_pkg::REG_MISMATCH_LIMIT, 13'd63);
      send_item(bwm_pkg::REQ_QUERY, 12'd0, random_word(), 32'd0);
      // A single base compared; bits above it are ignored.
      set_regs(0, 1, 8);
      send_item(bwm_pkg::REQ_QUERY, 12'd0, {random_word() & ~64'd3} | 64'd2,
                32'hffff_fffe);
      // Scan counts at and above the store size, stopped by a stored entry.
      set_regs(0, 32, 8191);
      send_item(bwm_pkg::REQ_QUERY, 12'd0, whitelist_copy[5], 32'd0);
      write_reg(bwm_pkg::REG_ENTRY_COUNT, 13'(ENTRIES));
      send_item(bwm_pkg::REQ_QUERY, 12'd0, whitelist_copy[20], 32'd0);
      // The top slot takes a write like any other.
      send_item(bwm_pkg::REQ_LOAD, 12'd4095, random_word(), 32'd0);
      write_reg(bwm_pkg::REG_ENTRY_COUNT, 13'd0);
      send_item(bwm_pkg::REQ_QUERY, 12'd0, random_word(), 32'd0);
   endtask

   task automatic test_random_traffic();
      int scan;
      int pick;
      int slot;
      logic [63:0] code;
      for (int phase = 0; phase < 7; phase++) begin
         no_gaps = (phase == 4);
         set_regs(($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(4),
                  ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(32, 8),
                  $urandom_range(FILLED, 1));
         scan = (count_reg > ENTRIES) ? ENTRIES : int'(count_reg);
         for (int i = 0; i < 14; i++) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
               send_near_query($urandom_range(scan - 1), $urandom_range(3), $urandom_range(2));
            end else if (pick < 85) begin
               slot = ($urandom_range(1) == 1) ? $urandom_range(scan - 1)
                                               : $urandom_range(ENTRIES - 1);
               code = random_word();
               if ($urandom_range(1) == 1) begin
                  code = whitelist_copy[$urandom_range(scan - 1)];
                  code[2 * $urandom_range(31) +: 2] = code[2 * $urandom_range(31) +: 2];
               end
               send_item(bwm_pkg::REQ_LOAD, 12'(slot), code, $urandom);
            end else begin
               send_item(bwm_pkg::REQ_QUERY, 12'($urandom), random_word(), $urandom);
            end
         end
      end
      no_gaps = 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_type = bwm_pkg::REQ_LOAD;
      req_entry_index = '0;
      req_barcode = '0;
      req_n_mask = '0;
      csr_valid = 1'b0;
      csr_index = bwm_pkg::REG_MISMATCH_LIMIT;
      csr_data = '0;
      limit_reg = 6'd1;
      length_reg = 6'd16;
      count_reg = 13'd0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_fill_whitelist();
      test_special_cases();
      test_random_traffic();

      @(negedge clock);
      start = 1'b0;
      while (expected_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
